@@ rtl/adfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adfe_pkg
// Types, constants and helpers shared by the decimal field extractor.
// ----------------------------------------------------------------------------
package adfe_pkg;

  // Payload widths
  localparam int CHAR_W   = 8;
  localparam int NUM_W    = 30;
  localparam int IDX_W    = 16;
  localparam int CNT_W    = 4;
  localparam int MAXD_W   = 4;
  localparam int MAXV_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int LIM_W    = 5;

  localparam int MAX_DIGITS_DEF = 9;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIGITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUES = 1'd1;

  // Register reset values
  localparam logic [MAXD_W-1:0] MAX_DIGITS_RST = 4'd9;
  localparam logic [MAXV_W-1:0] MAX_VALUES_RST = 16'd64;

  // Largest value the number field can show
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  // One result word
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [IDX_W-1:0] number_index;
    logic             number_valid;
    logic             overflow;
    logic             line_end;
  } res_t;

  // 10 to the power n, for sizing the accumulator at elaboration
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // Accumulator width: enough for the widest kept run, never below NUM_W
  function automatic int acc_width(input int digits);
    int w;
    w = $clog2(pow10(digits));
    return (w < NUM_W) ? NUM_W : w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/adfe_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adfe_parse
// Line state and single-pass digit accumulation for one character a cycle while fire_i is high.
// ----------------------------------------------------------------------------
module adfe_parse
  import adfe_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [CHAR_W-1:0] char_i,
  input  wire logic [MAXD_W-1:0] max_digits_i,
  input  wire logic [MAXV_W-1:0] max_values_i,
  output logic                   has_res_o,
  output res_t                   res_o
);

  localparam int ACC_W = acc_width(MAX_DIGITS);
  localparam logic [LIM_W-1:0] MAXD_LIM = LIM_W'(MAX_DIGITS);

  logic [ACC_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] nil_q, nil_d;

  logic             is_digit;
  logic             is_nl;
  logic [3:0]       digit;
  logic [LIM_W-1:0] limit;
  logic [ACC_W-1:0] acc_x10;
  logic [NUM_W-1:0] num_sat;
  logic             room;

  always_comb begin
    is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
    is_nl    = (char_i == CHAR_NEWLINE);
    digit    = 4'(char_i - CHAR_ZERO);
    limit    = (LIM_W'(max_digits_i) < MAXD_LIM) ? LIM_W'(max_digits_i) : MAXD_LIM;
    acc_x10  = (acc_q << 3) + (acc_q << 1);
    num_sat  = (acc_q > ACC_W'(NUM_MAX)) ? NUM_MAX : acc_q[NUM_W-1:0];
    room     = (nil_q < max_values_i);

    acc_d     = acc_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    nil_d     = nil_q;
    has_res_o = 1'b0;
    res_o     = '0;

    if (is_digit) begin
      // keep the digit only while under the limit
      if (LIM_W'(cnt_q) < limit) begin
        acc_d  = acc_x10 + ACC_W'(digit);
        cnt_d  = cnt_q + 1'b1;
        pend_d = 1'b1;
      end
    end else if (is_nl || pend_q) begin
      has_res_o = 1'b1;
      res_o.line_end = is_nl;
      if (pend_q) begin
        res_o.number       = num_sat;
        res_o.number_index = nil_q;
        res_o.number_valid = room;
        res_o.overflow     = !room;
        if (room) begin
          nil_d = nil_q + 1'b1;
        end
      end
      acc_d  = '0;
      cnt_d  = '0;
      pend_d = 1'b0;
      if (is_nl) begin
        nil_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
      nil_q  <= '0;
    end else if (fire_i) begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      nil_q  <= nil_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ascii_decimal_field_extractor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_decimal_field_extractor
// Splits an ASCII byte stream into unsigned decimal numbers, one per digit run.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one ASCII word per
//   cycle. Digit runs build a number; any other byte ends a pending number,
//   and a newline also closes the line with a result marked line_end.
//   The output channel (out_valid_o / out_ready_i) carries one result word
//   for each separator that ends a number and for each newline.
//   An accepted word lands in the input register, and its result, if any,
//   is loaded from there into the result register when the word advances.
//   Throughput: one word per cycle outside stalls; the accumulator update is a
//   shift-add (times ten plus digit) between the input and result registers.
//   Stall: while a result waits, words that give no result keep flowing;
//   a word that gives a result holds in the input register until the
//   result register frees, and in_ready_o is low only while it holds there.
//   Reset: clears line state and both registers; max_digits returns to 9
//   and max_values to 64. Write config through cfg_we_i only when idle.
// ----------------------------------------------------------------------------
module ascii_decimal_field_extractor
  import adfe_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CHAR_W-1:0]    char_in_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [NUM_W-1:0]          number_o,
  output logic [IDX_W-1:0]          number_index_o,
  output logic                      number_valid_o,
  output logic                      overflow_o,
  output logic                      line_end_o
);

  logic [MAXD_W-1:0] max_digits_q;
  logic [MAXV_W-1:0] max_values_q;

  logic              in_valid_q;
  logic [CHAR_W-1:0] char_q;

  logic              out_valid_q;
  res_t              res_q;

  logic              has_res;
  res_t              res_d;
  logic              out_free;
  logic              fire;
  logic              load;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_digits_q <= MAX_DIGITS_RST;
      max_values_q <= MAX_VALUES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_DIGITS: max_digits_q <= cfg_wdata_i[MAXD_W-1:0];
        REG_MAX_VALUES: max_values_q <= cfg_wdata_i[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held word when its result (if any) has somewhere to go
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && (!has_res || out_free);
  assign load       = fire && has_res;
  assign in_ready_o = !in_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_in_i;
    end
  end

  adfe_parse #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .char_i       (char_q),
    .max_digits_i (max_digits_q),
    .max_values_i (max_values_q),
    .has_res_o    (has_res),
    .res_o        (res_d)
  );

  // Result register: load a new result, drop the old one once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign number_o       = res_q.number;
  assign number_index_o = res_q.number_index;
  assign number_valid_o = res_q.number_valid;
  assign overflow_o     = res_q.overflow;
  assign line_end_o     = res_q.line_end;

endmodule

`default_nettype wire

@@ verif/tb_ascii_decimal_field_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_decimal_field_extractor
// Self-checking bench for the decimal field extractor. A short directed
// stream (typed-in results for the obvious cases) is followed by random
// lines of digit runs and separators over several register settings and
// handshake idling profiles. Every accepted word is run through a local
// line parser; every result word is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_ascii_decimal_field_extractor;
  import adfe_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_WORDS   = 270;  // least accepted words per random phase; whole lines are sent
  localparam int SETTLE_CYCLES = 6;    // covers input register plus result register

  // Separator characters used by the stimulus
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE = " ";
  localparam logic [CHAR_W-1:0] CH_COMMA = ",";
  localparam logic [CHAR_W-1:0] CH_MINUS = "-";
  localparam logic [CHAR_W-1:0] CH_SEMI  = ";";
  localparam logic [CHAR_W-1:0] CH_SLASH = "/";
  localparam logic [CHAR_W-1:0] CH_COLON = ":";

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // One row of the directed stream: a word to send or a register write
  typedef struct {
    row_kind_e              kind;
    logic [CFG_W-1:0]       data;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic                   known;
    res_t                   exp;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CHAR_W-1:0]    char_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [NUM_W-1:0]     number_o;
  logic [IDX_W-1:0]     number_index_o;
  logic                 number_valid_o;
  logic                 overflow_o;
  logic                 line_end_o;

  // Typed-in result that travels with the word on the input channel
  logic word_known;
  res_t word_exp;

  // Local copy of the registers and of the line state
  logic [MAXD_W-1:0] cfg_max_digits = MAX_DIGITS_RST;
  logic [MAXV_W-1:0] cfg_max_values = MAX_VALUES_RST;
  logic [NUM_W-1:0]  line_acc       = '0;
  logic [CNT_W-1:0]  line_digits    = '0;
  logic              line_pending   = 1'b0;
  logic [IDX_W-1:0]  line_count     = '0;

  res_t        pending_results_q[$];
  dir_row_t    directed_q[$];
  int unsigned sent_words     = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int          snd_idle_pct   = 0;
  int          rcv_stall_pct  = 0;
  int          rx_hold_cycles = 0;

  ascii_decimal_field_extractor DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_in_i      (char_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .number_o       (number_o),
    .number_index_o (number_index_o),
    .number_valid_o (number_valid_o),
    .overflow_o     (overflow_o),
    .line_end_o     (line_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs or drops a result
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Line parser: advance the local state by one accepted word. has_res says
  // whether the word yields a result.
  // --------------------------------------------------------------------------
  task automatic parse_char(input logic [CHAR_W-1:0] c, output logic has_res,
                            output res_t r);
    int unsigned lim;
    lim     = (cfg_max_digits < MAX_DIGITS_DEF) ? cfg_max_digits : MAX_DIGITS_DEF;
    has_res = 1'b0;
    r       = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      // Keep the digit only while the run is below the digit limit
      if (line_digits < lim) begin
        line_acc     = NUM_W'(line_acc * 10 + (c - CHAR_ZERO));
        line_digits  = line_digits + 1'b1;
        line_pending = 1'b1;
      end
    end else begin
      // Any other byte closes a pending number
      if (line_pending) begin
        r.number       = line_acc;
        r.number_index = line_count;
        if (line_count < cfg_max_values) begin
          r.number_valid = 1'b1;
          line_count     = line_count + 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
        line_acc     = '0;
        line_digits  = '0;
        line_pending = 1'b0;
        has_res      = 1'b1;
      end
      // A newline always gives a result and starts a fresh line
      if (c == CHAR_NEWLINE) begin
        r.line_end = 1'b1;
        line_count = '0;
        has_res    = 1'b1;
      end
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: check the result word first, then predict from the input
  // word accepted at the same edge. Both sides read pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    res_t want;
    res_t pred;
    logic has_res;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got number %0d index %0d",
                   $time, number_o, number_index_o);
        end else begin
          want = pending_results_q.pop_front();
          report_field("number",       want.number,       number_o);
          report_field("number_index", want.number_index, number_index_o);
          report_field("number_valid", want.number_valid, number_valid_o);
          report_field("overflow",     want.overflow,     overflow_o);
          report_field("line_end",     want.line_end,     line_end_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        parse_char(char_in_i, has_res, pred);
        sent_words++;
        if (has_res) pending_results_q.push_back(word_known ? word_exp : pred);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: a long hold-off when asked, else random stalls at the set rate
  // --------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Offer one word; idle gaps first, then hold valid until the handshake
  task automatic send_word(input logic [CHAR_W-1:0] c, input logic known, input res_t exp);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    word_known <= known;
    word_exp   <= exp;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Registers change only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_DIGITS) cfg_max_digits = value[MAXD_W-1:0];
    else cfg_max_values = value[MAXV_W-1:0];
  endtask

  function automatic logic [CHAR_W-1:0] pick_separator();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(5))
      0: c = CH_SPACE;
      1: c = CH_COMMA;
      2: c = CH_MINUS;
      3: c = CH_SEMI;
      4: c = CH_TAB;
      default: begin
        // Any byte that neither extends a run nor ends the line
        do c = CHAR_W'($urandom_range(255));
        while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_NEWLINE);
      end
    endcase
    return c;
  endfunction

  // Mostly well-formed lines of numbers; some noise and unterminated lines
  task automatic send_random_line();
    int n_nums;
    int run_len;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(6, 1)) send_word(CHAR_W'($urandom_range(255)), 1'b0, '0);
    end else begin
      n_nums = $urandom_range(6);
      for (int k = 0; k < n_nums; k++) begin
        if ($urandom_range(99) < 30) send_word(pick_separator(), 1'b0, '0);
        // Most runs fit the digit limit; some run past it to hit the drop
        if ($urandom_range(99) < 85) run_len = $urandom_range(cfg_max_digits, 1);
        else run_len = $urandom_range(12, cfg_max_digits + 1);
        repeat (run_len) send_word(CHAR_W'(CHAR_ZERO + $urandom_range(9)), 1'b0, '0);
        // The last number may run straight into the newline
        if (k < n_nums - 1 || $urandom_range(99) < 70) send_word(pick_separator(), 1'b0, '0);
      end
      if ($urandom_range(99) < 92) send_word(CHAR_NEWLINE, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int maxd, input int maxv, input int snd, input int rcv,
                           input int hold);
    int unsigned start;
    write_reg(REG_MAX_DIGITS, maxd);
    write_reg(REG_MAX_VALUES, maxv);
    snd_idle_pct   = snd;
    rcv_stall_pct  = rcv;
    rx_hold_cycles = hold;
    start = sent_words;
    while (sent_words - start < PHASE_WORDS) send_random_line();
  endtask

  function automatic dir_row_t word_row(input logic [CHAR_W-1:0] c);
    dir_row_t r;
    r = '{kind: ROW_WORD, data: CFG_W'(c), reg_idx: '0, known: 1'b0, exp: '0};
    return r;
  endfunction

  function automatic dir_row_t known_row(input logic [CHAR_W-1:0] c, input int unsigned num,
                                         input int unsigned idx, input logic vld,
                                         input logic ovf, input logic le);
    dir_row_t r;
    r = word_row(c);
    r.known = 1'b1;
    r.exp   = '{number: NUM_W'(num), number_index: IDX_W'(idx), number_valid: vld,
                overflow: ovf, line_end: le};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
    dir_row_t r;
    r = '{kind: ROW_CFG, data: CFG_W'(v), reg_idx: idx, known: 1'b0, exp: '0};
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    char_in_i   = '0;
    word_known  = 1'b0;
    word_exp    = '0;

    // Reset registers: nine digits kept, 64 numbers per line
    directed_q.push_back(known_row(CHAR_NEWLINE, 0, 0, 1'b0, 1'b0, 1'b1)); // empty line
    directed_q.push_back(word_row(CHAR_ZERO));
    directed_q.push_back(known_row(CH_COMMA, 0, 0, 1'b1, 1'b0, 1'b0));
    repeat (9) directed_q.push_back(word_row(CHAR_NINE));
    directed_q.push_back(word_row(CHAR_ZERO + 8'd5));                       // past the limit
    directed_q.push_back(known_row(CH_MINUS, 999999999, 1, 1'b1, 1'b0, 1'b0));
    // Separators with nothing pending, including both neighbors of the digits
    directed_q.push_back(word_row(8'hFF));
    directed_q.push_back(word_row(8'h00));
    directed_q.push_back(word_row(CH_SLASH));
    directed_q.push_back(word_row(CH_COLON));
    directed_q.push_back(word_row(CHAR_ZERO + 8'd7));
    directed_q.push_back(known_row(CHAR_NEWLINE, 7, 2, 1'b1, 1'b0, 1'b1));
    // One digit per number, one number per line
    directed_q.push_back(cfg_row(REG_MAX_DIGITS, 1));
    directed_q.push_back(cfg_row(REG_MAX_VALUES, 1));
    directed_q.push_back(word_row(CHAR_ZERO + 8'd1));
    directed_q.push_back(word_row(CHAR_ZERO + 8'd2));
    directed_q.push_back(known_row(CH_SPACE, 1, 0, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(word_row(CHAR_ZERO + 8'd5));
    directed_q.push_back(known_row(CHAR_NEWLINE, 5, 1, 1'b0, 1'b1, 1'b1)); // overflow at eol

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      if (directed_q[i].kind == ROW_CFG) begin
        write_reg(directed_q[i].reg_idx, directed_q[i].data);
      end else begin
        send_word(directed_q[i].data[CHAR_W-1:0], directed_q[i].known, directed_q[i].exp);
      end
    end

    // Random phases: digits, values, sender idle %, receiver stall %, hold-off
    run_phase(9, 64,    0,  0,  0);
    run_phase(1, 1,     58, 0,  0);
    run_phase(4, 3,     0,  58, 0);
    run_phase(9, 65535, 16, 16, 0);
    // Long receiver hold-off while the sender keeps pushing: fills the block
    run_phase(2, 2,     0,  0,  300);
    run_phase(6, 4,     16, 16, 0);

    drain_results();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/adfe_pkg.sv
rtl/adfe_parse.sv
rtl/ascii_decimal_field_extractor.sv
verif/tb_ascii_decimal_field_extractor.sv
